/* hw/rtl/ray_box_intersect_core_defines.svh */
// Assertion macros for the ray versus box intersection core.
`ifndef RAY_BOX_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_INTERSECT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RBI_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbi assertion failed");
`define RBI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbi assertion failed");
`else
`define RBI_ASSERT_IMPLY(lbl, ante, cons)
`define RBI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/rbi_pkg.sv */
// Types shared by the stages of the ray versus box intersection core.
package rbi_pkg;
	typedef struct packed {
		logic signed [31:0] o;
		logic signed [31:0] d;
		logic signed [33:0] lo;
		logic signed [33:0] hi;
	} edge_t;

	typedef struct packed {
		logic signed [31:0] d;
		logic signed [34:0] dlo;
		logic signed [34:0] dhi;
		logic [31:0]        tn;
		logic [31:0]        td;
		logic               cand;
	} axis_t;
endpackage

/* hw/rtl/ray_box_intersect_core.sv */
// Top level of the pipelined ray versus axis-aligned box intersection core.
//  channel  | direction | tdata               | meaning
//  s_axis   | in        | 384 bits            | one ray and one box per transfer
//  m_axis   | out       | 8 bits              | hit flag, one transfer per input
// One transfer is accepted per cycle while the output is not stalled; there are
// six register stages (edges, classes, cross products, choice, bounds products,
// compare). Reset clears only the stage valid bits. A stall on the output
// freezes every stage at once, so no transfer is lost or repeated.
`include "ray_box_intersect_core_defines.svh"
module ray_box_intersect_core import rbi_pkg::*; #(
	parameter int AXES = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_center_x,
	// box_center_y, box_center_z (32 bits each), box_half_x, box_half_y,
	// box_half_z (31 bits each), three zero bits.
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, seven zero bits.
	output logic [7:0]   m_tdata
);
	localparam int IW = (AXES > 2) ? 2 : 1;

	logic signed [31:0] o_w [AXES];
	logic signed [31:0] d_w [AXES];
	logic signed [31:0] c_w [AXES];
	logic [30:0]        h_w [AXES];
	logic               en;
	logic               v2;
	logic               v4;
	logic               v6;
	logic               inside2;
	logic               inside4;
	logic               have4;
	logic [IW-1:0]      best4;
	logic [31:0]        tn4;
	logic [31:0]        td4;
	axis_t              ax2 [AXES];
	axis_t              ax4 [AXES];
	logic               hit6;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			o_w[i] = s_tdata[32*i +: 32];
			d_w[i] = s_tdata[96 + 32*i +: 32];
			c_w[i] = s_tdata[192 + 32*i +: 32];
			h_w[i] = s_tdata[288 + 31*i +: 31];
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rbi_prep #(.AXES(AXES)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(s_tvalid),
		.o_in(o_w), .d_in(d_w), .c_in(c_w), .h_in(h_w),
		.vout(v2), .inside_s2(inside2), .ax_s2(ax2)
	);

	rbi_select #(.AXES(AXES), .IW(IW)) u_select (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v2),
		.inside_in(inside2), .ax_in(ax2),
		.vout(v4), .inside_s4(inside4), .have_s4(have4), .best_s4(best4),
		.tn_s4(tn4), .td_s4(td4), .ax_s4(ax4)
	);

	rbi_bounds #(.AXES(AXES), .IW(IW)) u_bounds (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v4),
		.inside_in(inside4), .have_in(have4), .best_in(best4),
		.tn_in(tn4), .td_in(td4), .ax_in(ax4),
		.vout(v6), .hit_s6(hit6)
	);

	assign m_tvalid = v6;
	assign m_tdata  = {7'b0000000, hit6};

	`RBI_ASSERT_IMPLY(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	`RBI_ASSERT_NEXT(a_accept_enters_pipe, s_tvalid && s_tready, $past(en))
	`RBI_ASSERT_NEXT(a_stall_holds_hit, m_tvalid && !m_tready, m_tvalid && $stable(hit6))
endmodule

/* hw/rtl/rbi_prep.sv */
// Box edges, slab classes, plane distances and candidate flags per axis.
module rbi_prep import rbi_pkg::*; #(
	parameter int AXES = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vin,
	input  logic signed [31:0]       o_in [AXES],
	input  logic signed [31:0]       d_in [AXES],
	input  logic signed [31:0]       c_in [AXES],
	input  logic [30:0]              h_in [AXES],
	output logic                     vout,
	output logic                     inside_s2,
	output axis_t                    ax_s2 [AXES]
);
	edge_t              e_s1 [AXES];
	logic               v_s1;
	logic               v_s2;
	axis_t              ax_c [AXES];
	logic [AXES-1:0]    in_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AXES; i++) begin
				e_s1[i].o  <= o_in[i];
				e_s1[i].d  <= d_in[i];
				e_s1[i].lo <= {{2{c_in[i][31]}}, c_in[i]} - {3'b000, h_in[i]};
				e_s1[i].hi <= {{2{c_in[i][31]}}, c_in[i]} + {3'b000, h_in[i]};
			end
			ax_s2     <= ax_c;
			inside_s2 <= &in_c;
		end
	end

	always_comb begin
		logic signed [33:0] ow;
		logic signed [34:0] n;
		logic signed [34:0] nm;
		logic signed [32:0] dm;
		logic below;
		logic above;
		for (int i = 0; i < AXES; i++) begin
			ow    = {{2{e_s1[i].o[31]}}, e_s1[i].o};
			below = ow < e_s1[i].lo;
			above = ow > e_s1[i].hi;
			ax_c[i].dlo = {e_s1[i].lo[33], e_s1[i].lo} - {{3{e_s1[i].o[31]}}, e_s1[i].o};
			ax_c[i].dhi = {e_s1[i].hi[33], e_s1[i].hi} - {{3{e_s1[i].o[31]}}, e_s1[i].o};
			n  = below ? ax_c[i].dlo : (above ? ax_c[i].dhi : 35'sd0);
			nm = n[34] ? -n : n;
			dm = e_s1[i].d[31] ? -{e_s1[i].d[31], e_s1[i].d} : {e_s1[i].d[31], e_s1[i].d};
			ax_c[i].d    = e_s1[i].d;
			ax_c[i].tn   = nm[31:0];
			ax_c[i].td   = dm[31:0];
			ax_c[i].cand = (below || above) && (e_s1[i].d != 32'sd0)
				&& (below == !e_s1[i].d[31]);
			in_c[i] = !(below || above);
		end
	end

	assign vout = v_s2;
endmodule

/* hw/rtl/rbi_select.sv */
// Cross products of plane distances and choice of the farthest candidate plane.
module rbi_select import rbi_pkg::*; #(
	parameter int AXES = 3,
	parameter int IW   = (AXES > 2) ? 2 : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic                inside_in,
	input  axis_t               ax_in [AXES],
	output logic                vout,
	output logic                inside_s4,
	output logic                have_s4,
	output logic [IW-1:0]       best_s4,
	output logic [31:0]         tn_s4,
	output logic [31:0]         td_s4,
	output axis_t               ax_s4 [AXES]
);
	logic [63:0]   pm_s3 [AXES][AXES];
	axis_t         ax_s3 [AXES];
	logic          inside_s3;
	logic          v_s3;
	logic          v_s4;
	logic          have_c;
	logic [IW-1:0] best_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= vin;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AXES; i++) begin
				for (int j = 0; j < AXES; j++) begin
					pm_s3[i][j] <= ax_in[i].tn * ax_in[j].td;
				end
			end
			ax_s3     <= ax_in;
			inside_s3 <= inside_in;
			ax_s4     <= ax_s3;
			inside_s4 <= inside_s3;
			have_s4   <= have_c;
			best_s4   <= best_c;
			tn_s4     <= ax_s3[best_c].tn;
			td_s4     <= ax_s3[best_c].td;
		end
	end

	always_comb begin
		have_c = 1'b0;
		best_c = '0;
		for (int i = 0; i < AXES; i++) begin
			if (ax_s3[i].cand && (!have_c || (pm_s3[best_c][i] < pm_s3[i][best_c]))) begin
				have_c = 1'b1;
				best_c = IW'(i);
			end
		end
	end

	assign vout = v_s4;
endmodule

/* hw/rtl/rbi_bounds.sv */
// Hit point bounds test on the axes other than the chosen plane.
module rbi_bounds import rbi_pkg::*; #(
	parameter int AXES = 3,
	parameter int IW   = (AXES > 2) ? 2 : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic                inside_in,
	input  logic                have_in,
	input  logic [IW-1:0]       best_in,
	input  logic [31:0]         tn_in,
	input  logic [31:0]         td_in,
	input  axis_t               ax_in [AXES],
	output logic                vout,
	output logic                hit_s6
);
	logic signed [67:0] p_s5  [AXES];
	logic signed [67:0] ql_s5 [AXES];
	logic signed [67:0] qh_s5 [AXES];
	logic               inside_s5;
	logic               have_s5;
	logic [IW-1:0]      best_s5;
	logic               v_s5;
	logic               v_s6;
	logic [AXES-1:0]    ok_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= vin;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AXES; i++) begin
				p_s5[i]  <= 68'($signed({1'b0, tn_in}) * ax_in[i].d);
				ql_s5[i] <= 68'(ax_in[i].dlo * $signed({1'b0, td_in}));
				qh_s5[i] <= 68'(ax_in[i].dhi * $signed({1'b0, td_in}));
			end
			inside_s5 <= inside_in;
			have_s5   <= have_in;
			best_s5   <= best_in;
			hit_s6    <= inside_s5 || (have_s5 && (&ok_c));
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			ok_c[i] = (best_s5 == IW'(i)) || ((ql_s5[i] <= p_s5[i]) && (p_s5[i] <= qh_s5[i]));
		end
	end

	assign vout = v_s6;
endmodule

/* sim/tb_ray_box_intersect_core.sv */
// Self-checking testbench for the ray versus axis-aligned box intersection core.
`timescale 1ns / 1ps
module tb_ray_box_intersect_core;
	localparam int AXES = 3;
	localparam int NAX = (AXES < 3) ? AXES : 3;

	typedef struct {
		logic signed [31:0] o [3];
		logic signed [31:0] d [3];
		logic signed [31:0] c [3];
		logic [30:0]        h [3];
	} ray_box_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [383:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;

	bit hit_q [$];
	int errors = 0;
	int sent = 0;
	int hits_seen = 0;
	int src_idle = 0;
	int dst_stall = 0;

	ray_box_intersect_core #(.AXES(AXES)) dut (.*);

	always #10 clk = ~clk;

	function automatic bit predict_hit(ray_box_t r);
		logic signed [35:0] lo [3], hi [3], n [3];
		logic [35:0] tn [3], td [3];
		bit valid [3];
		bit all_in;
		int best;
		logic signed [127:0] p, a, b;
		all_in = 1;
		best = -1;
		for (int i = 0; i < NAX; i++) begin
			lo[i] = 36'(r.c[i]) - 36'(signed'({1'b0, r.h[i]}));
			hi[i] = 36'(r.c[i]) + 36'(signed'({1'b0, r.h[i]}));
			valid[i] = 1;
			n[i] = 0;
			if (36'(r.o[i]) < lo[i]) n[i] = lo[i] - 36'(r.o[i]);
			else if (36'(r.o[i]) > hi[i]) n[i] = hi[i] - 36'(r.o[i]);
			else valid[i] = 0;
			if (valid[i]) all_in = 0;
			valid[i] = valid[i] && r.d[i] != 0 && ((n[i] > 0) == (r.d[i] > 0));
			tn[i] = n[i] < 0 ? -n[i] : n[i];
			td[i] = r.d[i] < 0 ? -36'(r.d[i]) : 36'(r.d[i]);
		end
		if (all_in) return 1;
		for (int i = 0; i < NAX; i++)
			if (valid[i] && (best < 0 || 72'(tn[best]) * 72'(td[i]) < 72'(tn[i]) * 72'(td[best])))
				best = i;
		if (best < 0) return 0;
		for (int i = 0; i < NAX; i++) begin
			if (i == best) continue;
			p = 128'(signed'({1'b0, tn[best]})) * 128'(r.d[i]);
			a = 128'(lo[i] - 36'(r.o[i])) * 128'(signed'({1'b0, td[best]}));
			b = 128'(hi[i] - 36'(r.o[i])) * 128'(signed'({1'b0, td[best]}));
			if (a > p || p > b) return 0;
		end
		return 1;
	endfunction

	task automatic send_ray_box(ray_box_t r);
		logic [383:0] bus;
		bus = '0;
		for (int i = 0; i < 3; i++) begin
			bus[32*i +: 32] = r.o[i];
			bus[96 + 32*i +: 32] = r.d[i];
			bus[192 + 32*i +: 32] = r.c[i];
			bus[288 + 31*i +: 31] = r.h[i];
		end
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= bus;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hit_q = {hit_q, predict_hit(r)};
		sent++;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(512)) - 256) <<< 12;
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			default: return 32'($signed($urandom_range(64)) - 32) <<< 16;
		endcase
	endfunction

	function automatic ray_box_t rand_ray_box();
		ray_box_t r;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = rand_coord();
			r.d[i] = ($urandom_range(7) == 0) ? 32'sd0 : rand_coord();
			r.c[i] = rand_coord();
			r.h[i] = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(20)) << 16;
		end
		if ($urandom_range(1)) begin
			for (int i = 0; i < 3; i++)
				r.d[i] = 32'(r.c[i]) - 32'(r.o[i]) + 32'($signed($urandom_range(4096)) - 2048);
		end
		return r;
	endfunction

	task automatic test_directed();
		ray_box_t r;
		for (int k = 0; k < 22; k++) begin
			for (int i = 0; i < 3; i++) begin
				r.o[i] = 0; r.d[i] = 0; r.c[i] = 0; r.h[i] = 31'h10000;
			end
			case (k)
				0: ;
				1: begin r.o[0] = -32'sh50000; r.d[0] = 32'sh10000; end
				2: begin r.o[0] = -32'sh50000; r.d[0] = -32'sh10000; end
				3: begin r.o[0] = -32'sh50000; end
				4: begin r.o[0] = -32'sh50000; r.d[0] = 32'sh10000; r.d[1] = 32'sh10000; end
				5: begin r.o[0] = -32'sh50000; r.d[0] = 32'sh40000; r.d[1] = 32'sh10000; end
				6: begin r.o[0] = -32'sh20000; r.o[1] = -32'sh20000;
					r.d[0] = 32'sh10000; r.d[1] = 32'sh10000; end
				7: begin r.o[0] = -32'sh20000; r.o[1] = 32'sh20000; r.d[0] = 32'sh10000; end
				8: begin r.o[0] = 32'h7fffffff; r.d[0] = 32'h80000000;
					r.c[0] = 32'h80000000; r.h[0] = 31'h7fffffff; end
				9: begin r.o[0] = 32'h80000000; r.d[0] = 32'h7fffffff;
					r.c[0] = 32'h7fffffff; r.h[0] = 31'h7fffffff; end
				10: begin r.o[0] = 32'h80000000; r.c[0] = 32'h7fffffff; r.h[0] = 0;
					r.d[0] = 32'h7fffffff; r.c[1] = 0; r.h[1] = 0; r.h[2] = 0; end
				11: begin r.o[2] = 32'sh30000; r.d[2] = -32'sh10000;
					r.d[0] = 32'sh8000; end
				12: begin r.o[2] = 32'sh30000; r.d[2] = -32'sh10000;
					r.d[0] = 32'sh10000; end
				13: begin r.o[2] = 32'sh30000; r.d[2] = -32'sh10000;
					r.d[0] = 32'sh10001; end
				14: begin r.o[0] = -32'sh20000; r.o[1] = -32'sh20000; r.o[2] = -32'sh20000;
					r.d[0] = 1; r.d[1] = 1; r.d[2] = 1; end
				15: begin r.o[1] = 32'sh10000; end
				16: begin r.o[1] = 32'sh10001; r.d[1] = 32'sh10000; end
				17: begin r.o[0] = 32'hffffffff; r.d[0] = 32'hffffffff;
					r.h[0] = 31'h7fffffff; end
				18: for (int i = 0; i < 3; i++) begin
					r.o[i] = 32'h80000000; r.d[i] = 32'h7fffffff; r.c[i] = 32'h7fffffff; end
				19: for (int i = 0; i < 3; i++) begin
					r.o[i] = 32'h7fffffff; r.d[i] = 32'h80000000; r.h[i] = 0; end
				20: begin r.o[0] = -32'sh30000; r.o[1] = 32'sh30000;
					r.d[0] = 32'sh10000; r.d[1] = -32'sh10000; end
				default: begin r.o[0] = -32'sh30000; r.d[0] = -32'sh10000;
					r.o[1] = 32'sh30000; r.d[1] = 32'sh10000; end
			endcase
			send_ray_box(r);
		end
		go_idle();
	endtask

	task automatic test_random(int count, int idle, int stall);
		src_idle = idle;
		dst_stall = stall;
		for (int k = 0; k < count; k++) send_ray_box(rand_ray_box());
		go_idle();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_q.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual hit=%0b",
					$time, m_tdata[0]);
				errors++;
			end else begin
				automatic bit want = hit_q.pop_front();
				if (m_tdata !== {7'd0, want}) begin
					$display("%0t: mismatch, expected %02h, actual %02h",
						$time, {7'd0, want}, m_tdata);
					errors++;
				end
				hits_seen += want;
			end
		end
		m_tready <= ($urandom_range(99) >= dst_stall);
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(190, 0, 0);
		test_random(190, 47, 0);
		test_random(190, 0, 47);
		test_random(190, 31, 31);
		dst_stall = 0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		$display("Sent %0d ray and box tests in four idle and stall phases, %0d hits.",
			sent, hits_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
